// ===== rtl/core/vbsp_pkg.sv =====
// vbsp_pkg: shared widths, register codes and word types for the vertex box select
// projection block; used by every module under rtl/core
package vbsp_pkg;

  // field widths
  localparam int IDX_W      = 16;
  localparam int COEF_W     = 16;
  localparam int POS_W      = 32;
  localparam int BOX_W      = 16;
  localparam int NORM_W     = 32;

  // dot product widths
  localparam int PROD_W     = COEF_W + POS_W;
  localparam int PAIR_W     = PROD_W + 1;
  localparam int CLIP_W     = PROD_W + 2;
  localparam int ONE_SHIFT  = 16;

  // divider widths
  localparam int MAG_W      = CLIP_W - 1;
  localparam int REM_W      = MAG_W + 1;
  localparam int INT_SHIFT  = 15;
  localparam int FRAC_W     = 16;
  localparam int QUO_W      = INT_SHIFT + FRAC_W;
  localparam int DIV_STEPS  = QUO_W;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 4 * COEF_W;

  localparam logic signed [BOX_W-1:0]  BOX_LO_RST = 16'shC000;
  localparam logic signed [BOX_W-1:0]  BOX_HI_RST = 16'sh4000;
  localparam logic signed [NORM_W-1:0] NORM_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [NORM_W-1:0] NORM_MIN   = 32'sh8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_X     = 3'd0,
    REG_ROW_Y     = 3'd1,
    REG_ROW_W     = 3'd2,
    REG_BOX_X_MIN = 3'd3,
    REG_BOX_X_MAX = 3'd4,
    REG_BOX_Y_MIN = 3'd5,
    REG_BOX_Y_MAX = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [IDX_W-1:0]        vert_id;
    logic                    on_surface;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0] picked_id;
    logic             inside_box;
    logic             surface_pick;
  } out_word_t;

  // side band that travels with the divider stages
  typedef struct packed {
    logic [IDX_W-1:0] id;
    logic             surf;
    logic             w_zero;
    logic             neg_x;
    logic             neg_y;
    logic             ovf_x;
    logic             ovf_y;
  } side_t;

endpackage

// ===== rtl/core/vbsp_dot.sv =====
// vbsp_dot: three stage multiply and add of one matrix row with the vertex
// depends on vbsp_pkg
module vbsp_dot
  import vbsp_pkg::*;
(
  input  logic                     clk,
  input  logic                     en,
  input  logic [CFG_DATA_W-1:0]    coefs,
  input  logic signed [POS_W-1:0]  pos_x,
  input  logic signed [POS_W-1:0]  pos_y,
  input  logic signed [POS_W-1:0]  pos_z,
  output logic signed [CLIP_W-1:0] clip
);

  logic signed [COEF_W-1:0] cx, cy, cz, cw;
  logic signed [PROD_W-1:0] px_r, py_r, pz_r, pw_r;
  logic signed [PROD_W-1:0] px_nxt, py_nxt, pz_nxt, pw_nxt;
  logic signed [PAIR_W-1:0] s01_r, s23_r;
  logic signed [CLIP_W-1:0] clip_r;

  // unpack the four coefficients
  assign cx = coefs[COEF_W-1:0];
  assign cy = coefs[2*COEF_W-1:COEF_W];
  assign cz = coefs[3*COEF_W-1:2*COEF_W];
  assign cw = coefs[4*COEF_W-1:3*COEF_W];

  // products at 28 fraction bits, w term is the coefficient times one
  always_comb begin
    px_nxt = PROD_W'(cx) * PROD_W'(pos_x);
    py_nxt = PROD_W'(cy) * PROD_W'(pos_y);
    pz_nxt = PROD_W'(cz) * PROD_W'(pos_z);
    pw_nxt = {{(PROD_W-COEF_W-ONE_SHIFT){cw[COEF_W-1]}}, cw, {ONE_SHIFT{1'b0}}};
  end

  // product, pair sum and final sum stages
  always_ff @(posedge clk) begin
    if (en) begin
      px_r   <= px_nxt;
      py_r   <= py_nxt;
      pz_r   <= pz_nxt;
      pw_r   <= pw_nxt;
      s01_r  <= PAIR_W'(px_r) + PAIR_W'(py_r);
      s23_r  <= PAIR_W'(pz_r) + PAIR_W'(pw_r);
      clip_r <= CLIP_W'(s01_r) + CLIP_W'(s23_r);
    end
  end

  assign clip = clip_r;

endmodule

// ===== rtl/core/vbsp_div.sv =====
// vbsp_div: pipelined restoring divider, one quotient bit per stage, for x and y
// over a shared w magnitude; depends on vbsp_pkg
module vbsp_div
  import vbsp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  side_t            in_side,
  input  logic [MAG_W-1:0] a_x,
  input  logic [MAG_W-1:0] a_y,
  input  logic [MAG_W-1:0] b,
  output logic             out_valid,
  output side_t            out_side,
  output logic [QUO_W-1:0] q_x,
  output logic [QUO_W-1:0] q_y
);

  logic             v_r    [0:DIV_STEPS];
  side_t            side_r [0:DIV_STEPS];
  logic [MAG_W-1:0] b_r    [0:DIV_STEPS];
  logic [MAG_W-1:0] rx_r   [0:DIV_STEPS];
  logic [MAG_W-1:0] ry_r   [0:DIV_STEPS];
  logic [QUO_W-1:0] lx_r   [0:DIV_STEPS];
  logic [QUO_W-1:0] ly_r   [0:DIV_STEPS];
  logic [QUO_W-1:0] qx_r   [0:DIV_STEPS];
  logic [QUO_W-1:0] qy_r   [0:DIV_STEPS];

  logic [MAG_W-1:0] hx, hy;
  side_t            side_nxt;

  // integer part: quotient of at least 2^15 saturates
  assign hx = MAG_W'(a_x[MAG_W-1:INT_SHIFT]);
  assign hy = MAG_W'(a_y[MAG_W-1:INT_SHIFT]);

  always_comb begin
    side_nxt       = in_side;
    side_nxt.ovf_x = (hx >= b);
    side_nxt.ovf_y = (hy >= b);
  end

  // entry stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_nxt;
      b_r[0]    <= b;
      rx_r[0]   <= hx;
      ry_r[0]   <= hy;
      lx_r[0]   <= {a_x[INT_SHIFT-1:0], {FRAC_W{1'b0}}};
      ly_r[0]   <= {a_y[INT_SHIFT-1:0], {FRAC_W{1'b0}}};
      qx_r[0]   <= '0;
      qy_r[0]   <= '0;
    end
  end

  // one quotient bit per stage
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [REM_W-1:0] tx, ty, dx, dy;
    logic             gx, gy;

    assign tx = {rx_r[k], lx_r[k][QUO_W-1]};
    assign ty = {ry_r[k], ly_r[k][QUO_W-1]};
    assign dx = tx - {1'b0, b_r[k]};
    assign dy = ty - {1'b0, b_r[k]};
    assign gx = (tx >= {1'b0, b_r[k]});
    assign gy = (ty >= {1'b0, b_r[k]});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[k+1] <= side_r[k];
        b_r[k+1]    <= b_r[k];
        rx_r[k+1]   <= gx ? dx[MAG_W-1:0] : tx[MAG_W-1:0];
        ry_r[k+1]   <= gy ? dy[MAG_W-1:0] : ty[MAG_W-1:0];
        lx_r[k+1]   <= {lx_r[k][QUO_W-2:0], 1'b0};
        ly_r[k+1]   <= {ly_r[k][QUO_W-2:0], 1'b0};
        qx_r[k+1]   <= {qx_r[k][QUO_W-2:0], gx};
        qy_r[k+1]   <= {qy_r[k][QUO_W-2:0], gy};
      end
    end
  end

  assign out_valid = v_r[DIV_STEPS];
  assign out_side  = side_r[DIV_STEPS];
  assign q_x       = qx_r[DIV_STEPS];
  assign q_y       = qy_r[DIV_STEPS];

endmodule

// ===== rtl/core/vbsp_box.sv =====
// vbsp_box: applies sign and saturation to the quotients, tests them against the
// rectangle and holds the output word register; depends on vbsp_pkg
module vbsp_box
  import vbsp_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  side_t                   side,
  input  logic [QUO_W-1:0]        q_x,
  input  logic [QUO_W-1:0]        q_y,
  input  logic signed [BOX_W-1:0] x_min,
  input  logic signed [BOX_W-1:0] x_max,
  input  logic signed [BOX_W-1:0] y_min,
  input  logic signed [BOX_W-1:0] y_max,
  output logic                    out_valid,
  output out_word_t               out_word
);

  logic signed [NORM_W-1:0] nx, ny, qxe, qye;
  logic signed [NORM_W-1:0] xlo, xhi, ylo, yhi;
  logic                     hit;
  logic                     valid_r;
  out_word_t                word_r, word_nxt;

  // signed and saturated Q16.16 results
  always_comb begin
    qxe = {1'b0, q_x};
    qye = {1'b0, q_y};
    if (side.ovf_x) begin
      nx = side.neg_x ? NORM_MIN : NORM_MAX;
    end else begin
      nx = side.neg_x ? -qxe : qxe;
    end
    if (side.ovf_y) begin
      ny = side.neg_y ? NORM_MIN : NORM_MAX;
    end else begin
      ny = side.neg_y ? -qye : qye;
    end
  end

  // bounds widened from Q2.14 to 16 fraction bits
  assign xlo = {{(NORM_W-BOX_W-2){x_min[BOX_W-1]}}, x_min, 2'b00};
  assign xhi = {{(NORM_W-BOX_W-2){x_max[BOX_W-1]}}, x_max, 2'b00};
  assign ylo = {{(NORM_W-BOX_W-2){y_min[BOX_W-1]}}, y_min, 2'b00};
  assign yhi = {{(NORM_W-BOX_W-2){y_max[BOX_W-1]}}, y_max, 2'b00};

  // strict rectangle test, zero w never passes
  always_comb begin
    hit = !side.w_zero && (nx > xlo) && (nx < xhi) && (ny > ylo) && (ny < yhi);
    word_nxt.picked_id    = side.id;
    word_nxt.inside_box   = hit;
    word_nxt.surface_pick = hit & side.surf;
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word_r <= word_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_word  = word_r;

endmodule

// ===== rtl/core/vertex_box_select_projection.sv =====
// vertex_box_select_projection: top level, configuration registers, abs stage and
// the stage enable; depends on vbsp_pkg, vbsp_dot, vbsp_div and vbsp_box
//
// Usage: one vertex word enters on in_valid/in_word when in_stall is low, one
// result word leaves on out_valid/out_word and is taken when out_stall is low.
// Each vertex gives exactly one result, in input order.
// Rows x, y and w of the projection matrix and the four rectangle bounds are
// written through cfg_we/cfg_idx/cfg_wdata while no word is in flight; an
// unknown index is ignored.
// The path runs through the row dot products, sign and magnitude, the divider
// entry, the restoring divider (one quotient bit per stage, x and y in
// parallel) and the rectangle test and output register.
// Throughput is one vertex per cycle while out_stall does not hold the pipeline.
// Reset clears every valid bit and loads the default rectangle of -1.0 to +1.0
// with all matrix coefficients zero.
// When the receiver stalls with a word waiting, the whole pipeline holds and
// in_stall rises in the same cycle; nothing is dropped or repeated.
module vertex_box_select_projection
  import vbsp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_word,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int DOT_STAGES = 3;

  logic [CFG_DATA_W-1:0]    row_x_r, row_y_r, row_w_r;
  logic signed [BOX_W-1:0]  box_x_min_r, box_x_max_r, box_y_min_r, box_y_max_r;

  logic                     adv;
  logic signed [CLIP_W-1:0] clip_x, clip_y, clip_w;

  logic                     dv_r   [0:DOT_STAGES-1];
  logic [IDX_W-1:0]         did_r  [0:DOT_STAGES-1];
  logic                     dsf_r  [0:DOT_STAGES-1];

  logic                     av_r;
  side_t                    aside_r, aside_nxt;
  logic [MAG_W-1:0]         ax_r, ay_r, aw_r;
  logic signed [CLIP_W-1:0] mx, my, mw;

  logic                     div_valid;
  side_t                    div_side;
  logic [QUO_W-1:0]         q_x, q_y;

  // the pipeline moves whenever the output register can take a word
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_x_r     <= '0;
      row_y_r     <= '0;
      row_w_r     <= '0;
      box_x_min_r <= BOX_LO_RST;
      box_x_max_r <= BOX_HI_RST;
      box_y_min_r <= BOX_LO_RST;
      box_y_max_r <= BOX_HI_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        REG_ROW_X:     row_x_r     <= cfg_wdata;
        REG_ROW_Y:     row_y_r     <= cfg_wdata;
        REG_ROW_W:     row_w_r     <= cfg_wdata;
        REG_BOX_X_MIN: box_x_min_r <= cfg_wdata[BOX_W-1:0];
        REG_BOX_X_MAX: box_x_max_r <= cfg_wdata[BOX_W-1:0];
        REG_BOX_Y_MIN: box_y_min_r <= cfg_wdata[BOX_W-1:0];
        REG_BOX_Y_MAX: box_y_max_r <= cfg_wdata[BOX_W-1:0];
        default: ;
      endcase
    end
  end

  // row dot products
  vbsp_dot u_dot_x (
    .clk   (clk),
    .en    (adv),
    .coefs (row_x_r),
    .pos_x (in_word.pos_x),
    .pos_y (in_word.pos_y),
    .pos_z (in_word.pos_z),
    .clip  (clip_x)
  );

  vbsp_dot u_dot_y (
    .clk   (clk),
    .en    (adv),
    .coefs (row_y_r),
    .pos_x (in_word.pos_x),
    .pos_y (in_word.pos_y),
    .pos_z (in_word.pos_z),
    .clip  (clip_y)
  );

  vbsp_dot u_dot_w (
    .clk   (clk),
    .en    (adv),
    .coefs (row_w_r),
    .pos_x (in_word.pos_x),
    .pos_y (in_word.pos_y),
    .pos_z (in_word.pos_z),
    .clip  (clip_w)
  );

  // index and surface flag alongside the dot product stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DOT_STAGES; i++) begin
        dv_r[i] <= 1'b0;
      end
    end else if (adv) begin
      dv_r[0] <= in_valid;
      for (int i = 1; i < DOT_STAGES; i++) begin
        dv_r[i] <= dv_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      did_r[0] <= in_word.vert_id;
      dsf_r[0] <= in_word.on_surface;
      for (int i = 1; i < DOT_STAGES; i++) begin
        did_r[i] <= did_r[i-1];
        dsf_r[i] <= dsf_r[i-1];
      end
    end
  end

  // sign and magnitude of the clip values
  always_comb begin
    mx = clip_x[CLIP_W-1] ? -clip_x : clip_x;
    my = clip_y[CLIP_W-1] ? -clip_y : clip_y;
    mw = clip_w[CLIP_W-1] ? -clip_w : clip_w;
    aside_nxt.id     = did_r[DOT_STAGES-1];
    aside_nxt.surf   = dsf_r[DOT_STAGES-1];
    aside_nxt.w_zero = (clip_w == '0);
    aside_nxt.neg_x  = clip_x[CLIP_W-1] ^ clip_w[CLIP_W-1];
    aside_nxt.neg_y  = clip_y[CLIP_W-1] ^ clip_w[CLIP_W-1];
    aside_nxt.ovf_x  = 1'b0;
    aside_nxt.ovf_y  = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      av_r <= 1'b0;
    end else if (adv) begin
      av_r <= dv_r[DOT_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      aside_r <= aside_nxt;
      ax_r    <= mx[MAG_W-1:0];
      ay_r    <= my[MAG_W-1:0];
      aw_r    <= mw[MAG_W-1:0];
    end
  end

  // divider pipeline
  vbsp_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (av_r),
    .in_side   (aside_r),
    .a_x       (ax_r),
    .a_y       (ay_r),
    .b         (aw_r),
    .out_valid (div_valid),
    .out_side  (div_side),
    .q_x       (q_x),
    .q_y       (q_y)
  );

  // rectangle test and output register
  vbsp_box u_box (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (div_valid),
    .side      (div_side),
    .q_x       (q_x),
    .q_y       (q_y),
    .x_min     (box_x_min_r),
    .x_max     (box_x_max_r),
    .y_min     (box_y_min_r),
    .y_max     (box_y_max_r),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

// ===== tb/vbsp_pick_checker.sv =====
// vbsp_pick_checker: watches the vertex, result and register ports of the box select block,
// predicts every result word and compares it; depends on vbsp_pkg only
module vbsp_pick_checker
  import vbsp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_word_t              in_word,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_word_t             out_word,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending
);

  // shadow copy of the block's registers
  logic [CFG_DATA_W-1:0]   row_x, row_y, row_w;
  logic signed [BOX_W-1:0] x_lo, x_hi, y_lo, y_hi;

  // results still owed by the block, oldest first
  out_word_t pick_q[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // one matrix row times (x, y, z, 1), 28 fraction bits
  function automatic longint row_times_vertex(input logic [CFG_DATA_W-1:0] row,
                                              input in_word_t v);
    longint cx, cy, cz, cw;
    cx = longint'($signed(row[15:0]));
    cy = longint'($signed(row[31:16]));
    cz = longint'($signed(row[47:32]));
    cw = longint'($signed(row[63:48]));
    return cx * longint'(v.pos_x) + cy * longint'(v.pos_y) + cz * longint'(v.pos_z)
           + cw * 65536;
  endfunction

  // clip / w as Q16.16, magnitude truncated, clamped to the 32 bit range
  function automatic longint normalize(input longint num, input longint den);
    logic [127:0] mag_n, mag_d, quo, cap;
    logic         flip;
    flip  = (num < 0) != (den < 0);
    mag_n = (num < 0) ? -num : num;
    mag_d = (den < 0) ? -den : den;
    quo   = (mag_n << 16) / mag_d;
    cap   = flip ? 128'h8000_0000 : 128'h7FFF_FFFF;
    if (quo > cap) quo = cap;
    return flip ? -longint'(quo) : longint'(quo);
  endfunction

  function automatic out_word_t predict_pick(input in_word_t v);
    out_word_t r;
    longint    clip_x, clip_y, clip_w, nx, ny;
    logic      hit;
    clip_x = row_times_vertex(row_x, v);
    clip_y = row_times_vertex(row_y, v);
    clip_w = row_times_vertex(row_w, v);
    hit = 1'b0;
    // a vertex with zero w never lands in the box
    if (clip_w != 0) begin
      nx  = normalize(clip_x, clip_w);
      ny  = normalize(clip_y, clip_w);
      hit = nx > 4 * longint'(x_lo) && nx < 4 * longint'(x_hi) &&
            ny > 4 * longint'(y_lo) && ny < 4 * longint'(y_hi);
    end
    r.picked_id    = v.vert_id;
    r.inside_box   = hit;
    r.surface_pick = hit & v.on_surface;
    return r;
  endfunction

  task automatic flag_field(input string field, input logic [IDX_W-1:0] want,
                            input logic [IDX_W-1:0] got);
    fail_count++;
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      row_x <= '0;
      row_y <= '0;
      row_w <= '0;
      x_lo  <= BOX_LO_RST;
      x_hi  <= BOX_HI_RST;
      y_lo  <= BOX_LO_RST;
      y_hi  <= BOX_HI_RST;
    end else begin
      // register writes, unknown index dropped
      if (cfg_we) begin
        case (cfg_idx)
          REG_ROW_X:     row_x <= cfg_wdata;
          REG_ROW_Y:     row_y <= cfg_wdata;
          REG_ROW_W:     row_w <= cfg_wdata;
          REG_BOX_X_MIN: x_lo  <= cfg_wdata[BOX_W-1:0];
          REG_BOX_X_MAX: x_hi  <= cfg_wdata[BOX_W-1:0];
          REG_BOX_Y_MIN: y_lo  <= cfg_wdata[BOX_W-1:0];
          REG_BOX_Y_MAX: y_hi  <= cfg_wdata[BOX_W-1:0];
          default: ;
        endcase
      end
      // result word against the oldest prediction
      if (out_valid && !out_stall) begin
        if (pick_q.size() == 0) begin
          fail_count++;
          $display("%0t: result word %0h with no vertex waiting", $time, out_word);
        end else begin
          want = pick_q.pop_front();
          if (out_word.picked_id !== want.picked_id)
            flag_field("picked_id", want.picked_id, out_word.picked_id);
          if (out_word.inside_box !== want.inside_box)
            flag_field("inside_box", want.inside_box, out_word.inside_box);
          if (out_word.surface_pick !== want.surface_pick)
            flag_field("surface_pick", want.surface_pick, out_word.surface_pick);
        end
      end
      // accepted vertex word
      if (in_valid && !in_stall)
        pick_q = {pick_q, predict_pick(in_word)};
      pending <= pick_q.size();
    end
  end

endmodule

// ===== tb/tb_vertex_box_select_projection.sv =====
// tb_vertex_box_select_projection: drives vertex words, register setups and result stalls
// into the box select block and reports the verdict; depends on vbsp_pkg and vbsp_pick_checker
module tb_vertex_box_select_projection;
  import vbsp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;  // no register behind this index
  localparam int ONE_Q16      = 65536;
  localparam int ONE_Q12      = 4096;
  localparam int POS_MAX      = 32'h7FFF_FFFF;
  localparam int POS_MIN      = int'(32'h8000_0000);
  localparam int N_RANDOM     = 450;
  localparam int DRAIN_CYCLES = 40;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  in_word_t              in_word   = '0;
  logic                  out_stall = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_stall;
  logic                  out_valid;
  out_word_t             out_word;
  int                    fail_count;
  int                    pending;
  logic                  quiet = 1'b0;  // no gaps and no stalls while set

  vertex_box_select_projection u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  vbsp_pick_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  // receiver stalls now and then
  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 7);
  end

  // hard stop
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int spread(input int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  function automatic logic [63:0] pack_row(input int cx, input int cy, input int cz,
                                           input int cw);
    return {cw[15:0], cz[15:0], cy[15:0], cx[15:0]};
  endfunction

  function automatic in_word_t vtx(input int x, input int y, input int z, input int id,
                                   input logic surf);
    in_word_t v;
    v.pos_x      = x;
    v.pos_y      = y;
    v.pos_z      = z;
    v.vert_id    = id[15:0];
    v.on_surface = surf;
    return v;
  endfunction

  // raw bits for every field
  function automatic in_word_t noise_vertex();
    return vtx($urandom, $urandom, $urandom, $urandom_range(65535),
               1'($urandom_range(1)));
  endfunction

  // a coordinate just around one bound, or anywhere near the box
  function automatic int near_bound(input logic signed [15:0] lo,
                                    input logic signed [15:0] hi);
    case ($urandom_range(2))
      0:       return 4 * int'(lo) + spread(2);
      1:       return 4 * int'(hi) + spread(2);
      default: return spread(2 * ONE_Q16);
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // all seven registers plus a write to the spare index; box words carry junk above bit 15
  task automatic load_setup(input logic [63:0] rx, input logic [63:0] ry,
                            input logic [63:0] rw, input logic [15:0] xl,
                            input logic [15:0] xh, input logic [15:0] yl,
                            input logic [15:0] yh);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    write_reg(REG_ROW_X, rx);
    write_reg(REG_ROW_Y, ry);
    write_reg(REG_ROW_W, rw);
    write_reg(REG_BOX_X_MIN, {junk[63:16], xl});
    write_reg(REG_BOX_X_MAX, {junk[47:0], xh});
    write_reg(REG_BOX_Y_MIN, {junk[55:8], yl});
    write_reg(REG_BOX_Y_MAX, {junk[31:0], junk[63:48], yh});
    write_reg(REG_SPARE, junk);
    cfg_we <= 1'b0;
  endtask

  // one vertex word, held until taken, then maybe a short gap
  task automatic send_vertex(input in_word_t v);
    in_valid <= 1'b1;
    in_word  <= v;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    if (!quiet && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  // let every owed result come out before touching registers
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_random_phase(input int count);
    int                 kind, i;
    logic signed [15:0] xl, xh, yl, yh, tmp;
    logic [63:0]        rx, ry, rw;
    in_word_t           v;
    kind = $urandom_range(9);
    xl = -16'($urandom_range(24576, 2048));
    xh = 16'($urandom_range(24576, 2048));
    yl = -16'($urandom_range(24576, 2048));
    yh = 16'($urandom_range(24576, 2048));
    rx = pack_row(ONE_Q12, 0, 0, 0);
    ry = pack_row(0, ONE_Q12, 0, 0);
    rw = pack_row(0, 0, 0, ONE_Q12);
    case (kind)
      6: rw = pack_row(0, 0, ONE_Q12, ONE_Q12);
      7: begin
        rx = {$urandom, $urandom};
        ry = {$urandom, $urandom};
        rw = {$urandom, $urandom};
        xl = 16'($urandom);
        xh = 16'($urandom);
        yl = 16'($urandom);
        yh = 16'($urandom);
      end
      8: ;
      9: begin
        // inverted x bounds, sometimes an empty y range too
        tmp = xl;
        xl  = xh;
        xh  = tmp;
        if ($urandom_range(1)) yh = yl;
      end
      default: begin
        // camera-like view with free sign of w
        rx = pack_row(spread(8192), spread(1024), spread(2048), spread(4096));
        ry = pack_row(spread(1024), spread(8192), spread(2048), spread(4096));
        rw = pack_row(spread(512), spread(512), spread(4096), spread(8192));
      end
    endcase
    load_setup(rx, ry, rw, xl, xh, yl, yh);
    for (i = 0; i < count; i++) begin
      case (kind)
        6: v = vtx(spread(2 * ONE_Q16), spread(2 * ONE_Q16),
                   ($urandom_range(3) == 0) ? -ONE_Q16 + spread(4) : spread(4 * ONE_Q16),
                   $urandom_range(65535), 1'($urandom_range(1)));
        7: v = noise_vertex();
        8, 9: v = vtx(near_bound(xl, xh), near_bound(yl, yh), $urandom,
                      $urandom_range(65535), 1'($urandom_range(1)));
        default: begin
          if ($urandom_range(15) == 0) v = noise_vertex();
          else v = vtx(spread(4 * ONE_Q16), spread(4 * ONE_Q16), spread(4 * ONE_Q16),
                       $urandom_range(65535), 1'($urandom_range(1)));
        end
      endcase
      send_vertex(v);
    end
  endtask

  initial begin
    int sent, phase, count;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset setup: w row is zero, nothing can be picked
    send_vertex(vtx(POS_MAX, POS_MIN, POS_MAX, 16'hFFFF, 1'b1));
    send_vertex(vtx(0, 0, 0, 0, 1'b1));
    drain();

    // identity view with w fixed at one, box edges are exclusive
    load_setup(pack_row(ONE_Q12, 0, 0, 0), pack_row(0, ONE_Q12, 0, 0),
               pack_row(0, 0, 0, ONE_Q12), BOX_LO_RST, BOX_HI_RST, BOX_LO_RST, BOX_HI_RST);
    send_vertex(vtx(0, 0, 0, 0, 1'b1));
    send_vertex(vtx(ONE_Q16 - 1, -(ONE_Q16 - 1), 0, 1, 1'b1));
    send_vertex(vtx(ONE_Q16, 0, 0, 2, 1'b1));
    send_vertex(vtx(-ONE_Q16, 0, 0, 3, 1'b0));
    send_vertex(vtx(0, ONE_Q16, 0, 4, 1'b1));
    send_vertex(vtx(0, -ONE_Q16, 0, 5, 1'b1));
    send_vertex(vtx(100, -100, POS_MAX, 16'hFFFF, 1'b0));
    send_vertex(vtx(POS_MIN, POS_MAX, POS_MIN, 16'h8000, 1'b1));
    drain();

    // w = 1 + z: zero w, negative w and tiny w that saturates the quotient
    load_setup(pack_row(ONE_Q12, 0, 0, 0), pack_row(0, ONE_Q12, 0, 0),
               pack_row(0, 0, ONE_Q12, ONE_Q12), BOX_LO_RST, BOX_HI_RST, BOX_LO_RST,
               BOX_HI_RST);
    send_vertex(vtx(0, 0, -ONE_Q16, 6, 1'b1));
    send_vertex(vtx(ONE_Q16 / 2, 0, -2 * ONE_Q16, 7, 1'b1));
    send_vertex(vtx(ONE_Q16, ONE_Q16, -ONE_Q16 - 1, 8, 1'b1));
    send_vertex(vtx(1, 0, -ONE_Q16 + 1, 9, 1'b1));
    send_vertex(vtx(0, 0, -ONE_Q16 + 1, 10, 1'b1));
    send_vertex(vtx(POS_MAX, POS_MIN, -ONE_Q16 + 1, 11, 1'b0));
    drain();

    // extreme coefficients, widest box
    load_setup(64'h7FFF_7FFF_7FFF_7FFF, 64'h8000_8000_8000_8000, 64'h8000_7FFF_8000_7FFF,
               16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
    send_vertex(vtx(POS_MAX, POS_MAX, POS_MAX, 12, 1'b1));
    send_vertex(vtx(POS_MIN, POS_MIN, POS_MIN, 13, 1'b1));
    send_vertex(vtx(0, 0, 0, 14, 1'b1));
    drain();

    // inverted x bounds
    load_setup(pack_row(ONE_Q12, 0, 0, 0), pack_row(0, ONE_Q12, 0, 0),
               pack_row(0, 0, 0, ONE_Q12), BOX_HI_RST, BOX_LO_RST, BOX_LO_RST, BOX_HI_RST);
    send_vertex(vtx(0, 0, 0, 15, 1'b1));
    send_vertex(vtx(3 * ONE_Q16 / 2, 0, 0, 16, 1'b1));
    drain();

    // empty y range
    load_setup(pack_row(ONE_Q12, 0, 0, 0), pack_row(0, ONE_Q12, 0, 0),
               pack_row(0, 0, 0, ONE_Q12), BOX_LO_RST, BOX_HI_RST, '0, '0);
    send_vertex(vtx(0, 0, 0, 17, 1'b1));
    send_vertex(vtx(0, 1, 0, 18, 1'b1));
    drain();

    // random setups, the third one without any gaps or stalls
    sent  = 0;
    phase = 0;
    while (sent < N_RANDOM) begin
      count = (phase == 2) ? 80 : $urandom_range(50, 20);
      quiet <= (phase == 2);
      run_random_phase(count);
      drain();
      sent += count;
      phase++;
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== vertex_box_select_projection.f =====
rtl/core/vbsp_pkg.sv
rtl/core/vbsp_dot.sv
rtl/core/vbsp_div.sv
rtl/core/vbsp_box.sv
rtl/core/vertex_box_select_projection.sv
tb/vbsp_pick_checker.sv
tb/tb_vertex_box_select_projection.sv
